// ===== hw/rtl/lcbm_pkg.sv =====
//------------------------------------------------------------------------------
// lcbm_pkg
// Shared types and constants of the loop candidate best-match selector.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcbm_pkg;

	typedef struct packed {
		logic               action;
		logic               pose_valid;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic [62:0]        stamp_ns;
		logic [31:0]        frame_id;
		logic               last;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [11:0]        best_position;
		logic [31:0]        best_frame_id;
		logic [62:0]        best_stamp;
		logic [31:0]        best_distance;
		logic [14:0]        best_yaw_gap;
		logic [15:0]        match_score;
		logic signed [63:0] best_time_gap;
	} result_t;

	localparam logic ACT_QUERY    = 1'b0;
	localparam logic ACT_KEYFRAME = 1'b1;

	localparam logic [1:0] REG_DIST_LIMIT = 2'd0;
	localparam logic [1:0] REG_YAW_LIMIT  = 2'd1;
	localparam logic [1:0] REG_MIN_GAP    = 2'd2;
	localparam logic [1:0] REG_MIN_SCORE  = 2'd3;

	localparam logic [1:0] SEL_DIST = 2'd0;
	localparam logic [1:0] SEL_YAW  = 2'd1;
	localparam logic [1:0] SEL_TIME = 2'd2;

	localparam logic [31:0] DIST_LIMIT_RST = 32'd196608;
	localparam logic [14:0] YAW_LIMIT_RST  = 15'd4096;
	localparam logic [39:0] MIN_GAP_RST    = 40'd10000000000;
	localparam logic [15:0] MIN_SCORE_RST  = 16'd32768;

	localparam logic [31:0] DIST_FLOOR = 32'd655;
	localparam logic [14:0] YAW_FLOOR  = 15'd82;
	localparam logic signed [17:0] PI_Q13     = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [32:0] W_DIST = 33'd32768;
	localparam logic [32:0] W_YAW  = 33'd13107;
	localparam logic [32:0] W_TIME = 33'd19661;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GATE,
		ST_MULX,
		ST_MULY,
		ST_SUM,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_LIMIT,
		ST_DIV,
		ST_DSTORE,
		ST_SCORE,
		ST_UPDATE,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load_query;
		logic       load_item;
		logic       gate;
		logic       mul_x;
		logic       mul_y;
		logic       sum;
		logic       root_load;
		logic       root_step;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic [1:0] div_sel;
		logic       score;
		logic       update;
		logic       emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic query_valid;
		logic gate_ok;
		logic sum_ovf;
		logic limit_ok;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcbm_ctrl.sv =====
//------------------------------------------------------------------------------
// lcbm_ctrl
// Sequencer: steps one keyframe through gating, root, divisions and scoring.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcbm_ctrl
	import lcbm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire logic     in_action,
	input  wire logic     in_last,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] sel_q, sel_d;
	logic       last_q, last_d;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= SEL_DIST;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			last_q  <= last_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		sel_d       = sel_q;
		last_d      = last_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_action == ACT_QUERY) begin
						cmd.load_query = 1'b1;
						if (in_last)
							state_d = ST_EMIT;
					end else if (stat.query_valid) begin
						cmd.load_item = 1'b1;
						last_d        = in_last;
						state_d       = ST_GATE;
					end else if (in_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_GATE: begin
				cmd.gate = 1'b1;
				state_d  = stat.gate_ok ? ST_MULX : ST_FIN;
			end
			ST_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_MULY;
			end
			ST_MULY: begin
				cmd.mul_y = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ROOT_INIT;
			end
			ST_ROOT_INIT: begin
				if (stat.sum_ovf) begin
					state_d = ST_FIN;
				end else begin
					cmd.root_load = 1'b1;
					cnt_d         = '0;
					state_d       = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = ST_LIMIT;
			end
			ST_LIMIT: begin
				if (stat.limit_ok) begin
					cmd.div_load = 1'b1;
					cmd.div_sel  = SEL_DIST;
					sel_d        = SEL_DIST;
					cnt_d        = '0;
					state_d      = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'd15)
					state_d = ST_DSTORE;
			end
			ST_DSTORE: begin
				cmd.div_store = 1'b1;
				cnt_d         = '0;
				if (sel_q == SEL_TIME) begin
					state_d = ST_SCORE;
				end else begin
					// Start the next ratio in the same cycle the last one is stored.
					sel_d        = sel_q + 2'd1;
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_SCORE: begin
				cmd.score = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcbm_dp.sv =====
//------------------------------------------------------------------------------
// lcbm_dp
// Datapath: registers, shared multiplier, square root, divider and best record.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcbm_dp
	import lcbm_pkg::*;
#(
	parameter int MAX_KEYFRAMES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [39:0] cfg_data,
	input  wire item_t       in_data,
	input  wire ctl_cmd_t    cmd,
	output dp_stat_t         stat,
	output result_t          out_data
);

	localparam int CAP_INT = (MAX_KEYFRAMES < 4096) ? MAX_KEYFRAMES - 1 : 4095;
	localparam logic [11:0] COUNT_CAP = 12'(CAP_INT);

	// Configuration registers.
	logic [31:0] dl_q;
	logic [14:0] yl_q;
	logic [39:0] mtg_q;
	logic [15:0] ms_q;

	// Query and working item.
	logic signed [31:0] qx_q, qy_q, kx_q, ky_q;
	logic signed [15:0] qh_q, kh_q;
	logic [62:0]        qs_q, ks_q;
	logic [31:0]        qf_q, kf_q;
	logic               kvalid_q, qvalid_q;
	logic [11:0]        cnt_q, pos_q;

	logic [31:0] ax_q, ay_q;
	logic [14:0] ayaw_q;
	logic signed [63:0] sep_q;
	logic [63:0] prod_q, acc_q;
	logic [64:0] sum_q;

	logic [63:0] sq_val_q;
	logic [34:0] sq_rem_q;
	logic [31:0] sq_root_q;

	logic [41:0] dv_rem_q;
	logic [15:0] dv_quo_q;
	logic        dv_sat_q;
	logic [16:0] ds_q, ys_q, ts_q, score_q;

	logic        have_best_q;
	logic [11:0] b_pos_q;
	logic [31:0] b_frame_q, b_dist_q;
	logic [62:0] b_stamp_q;
	logic [14:0] b_yaw_q;
	logic [16:0] b_score_q;
	logic signed [63:0] b_gap_q;

	result_t out_q;

	// Gating logic on the working item.
	logic signed [63:0] sep;
	logic signed [32:0] dx, dy;
	logic [31:0]        adx, ady;
	logic signed [17:0] yd, yw;
	logic [14:0]        ayaw;

	always_comb begin
		sep = $signed({1'b0, qs_q}) - $signed({1'b0, ks_q});
		dx  = $signed({qx_q[31], qx_q}) - $signed({kx_q[31], kx_q});
		dy  = $signed({qy_q[31], qy_q}) - $signed({ky_q[31], ky_q});
		adx = dx[32] ? 32'(-dx) : dx[31:0];
		ady = dy[32] ? 32'(-dy) : dy[31:0];
		yd  = $signed({{2{qh_q[15]}}, qh_q}) - $signed({{2{kh_q[15]}}, kh_q});
		if (yd > PI_Q13)
			yw = yd - TWO_PI_Q13;
		else if (yd < -PI_Q13)
			yw = yd + TWO_PI_Q13;
		else
			yw = yd;
		ayaw = yw[17] ? 15'(-yw) : yw[14:0];
	end

	assign stat.query_valid = qvalid_q;
	assign stat.gate_ok     = kvalid_q && (kf_q != qf_q)
		&& !(sep < $signed({24'd0, mtg_q}));
	assign stat.sum_ovf     = sum_q[64];
	assign stat.limit_ok    = (sq_root_q <= dl_q) && (ayaw_q <= yl_q);

	// Shared multiplier operand.
	logic [31:0] mul_a;
	assign mul_a = cmd.mul_y ? ay_q : ax_q;

	// Square root step, two bits of the radicand per cycle.
	logic [34:0] rt_rem, rt_trial;
	assign rt_rem   = {sq_rem_q[32:0], sq_val_q[63:62]};
	assign rt_trial = {1'b0, sq_root_q, 2'b01};

	// Divider operands.
	logic [31:0] ddiv;
	logic [14:0] ydiv;
	logic [40:0] tdiv, den;
	logic [63:0] num;
	logic [41:0] dv_t;
	logic [1:0]  ld_sel;

	// The store reports the finished ratio; a load beside it starts the next one.
	assign ld_sel = cmd.div_store ? cmd.div_sel + 2'd1 : cmd.div_sel;

	always_comb begin
		ddiv = (dl_q > DIST_FLOOR) ? dl_q : DIST_FLOOR;
		ydiv = (yl_q > YAW_FLOOR) ? yl_q : YAW_FLOOR;
		tdiv = (mtg_q == '0) ? 41'd1 : {mtg_q, 1'b0};
		case (ld_sel)
			SEL_DIST: begin
				num = {32'd0, sq_root_q};
				den = {9'd0, ddiv};
			end
			SEL_YAW: begin
				num = {49'd0, ayaw_q};
				den = {26'd0, ydiv};
			end
			default: begin
				num = sep_q;
				den = tdiv;
			end
		endcase
		dv_t = {dv_rem_q[40:0], 1'b0};
	end

	logic [16:0] ratio;
	assign ratio = dv_sat_q ? ONE_Q16 : {1'b0, dv_quo_q};

	logic [32:0] wsum;
	assign wsum = W_DIST * {16'd0, ds_q} + W_YAW * {16'd0, ys_q} + W_TIME * {16'd0, ts_q};

	logic take;
	assign take = (score_q >= {1'b0, ms_q}) && (!have_best_q || score_q > b_score_q);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q        <= DIST_LIMIT_RST;
			yl_q        <= YAW_LIMIT_RST;
			mtg_q       <= MIN_GAP_RST;
			ms_q        <= MIN_SCORE_RST;
			qvalid_q    <= 1'b0;
			cnt_q       <= '0;
			have_best_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIST_LIMIT: dl_q  <= cfg_data[31:0];
					REG_YAW_LIMIT:  yl_q  <= cfg_data[14:0];
					REG_MIN_GAP:    mtg_q <= cfg_data;
					default:        ms_q  <= cfg_data[15:0];
				endcase
			end
			if (cmd.load_query) begin
				qvalid_q    <= in_data.pose_valid;
				cnt_q       <= '0;
				have_best_q <= 1'b0;
			end else if (cmd.load_item) begin
				if (cnt_q < COUNT_CAP)
					cnt_q <= cnt_q + 12'd1;
			end else if (cmd.update && take) begin
				have_best_q <= 1'b1;
			end else if (cmd.emit) begin
				qvalid_q    <= 1'b0;
				cnt_q       <= '0;
				have_best_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q <= in_data.pos_x;
			qy_q <= in_data.pos_y;
			qh_q <= in_data.heading;
			qs_q <= in_data.stamp_ns;
			qf_q <= in_data.frame_id;
		end
		if (cmd.load_item) begin
			kx_q     <= in_data.pos_x;
			ky_q     <= in_data.pos_y;
			kh_q     <= in_data.heading;
			ks_q     <= in_data.stamp_ns;
			kf_q     <= in_data.frame_id;
			kvalid_q <= in_data.pose_valid;
			pos_q    <= cnt_q;
		end
		if (cmd.gate) begin
			ax_q   <= adx;
			ay_q   <= ady;
			ayaw_q <= ayaw;
			sep_q  <= sep;
		end
		if (cmd.mul_x || cmd.mul_y)
			prod_q <= mul_a * mul_a;
		if (cmd.mul_y)
			acc_q <= prod_q;
		if (cmd.sum)
			sum_q <= {1'b0, acc_q} + {1'b0, prod_q};
		if (cmd.root_load) begin
			sq_val_q  <= sum_q[63:0];
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (cmd.root_step) begin
			sq_val_q <= {sq_val_q[61:0], 2'b00};
			if (rt_rem >= rt_trial) begin
				sq_rem_q  <= rt_rem - rt_trial;
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= rt_rem;
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				SEL_DIST: ds_q <= ONE_Q16 - ratio;
				SEL_YAW:  ys_q <= ONE_Q16 - ratio;
				default:  ts_q <= ratio;
			endcase
		end
		// A load issued with a store sees the already advanced select.
		if (cmd.div_load) begin
			dv_sat_q <= (num >= {23'd0, den});
			dv_rem_q <= {1'b0, num[40:0]};
			dv_quo_q <= '0;
		end else if (cmd.div_step) begin
			if (dv_t >= {1'b0, den}) begin
				dv_rem_q <= dv_t - {1'b0, den};
				dv_quo_q <= {dv_quo_q[14:0], 1'b1};
			end else begin
				dv_rem_q <= dv_t;
				dv_quo_q <= {dv_quo_q[14:0], 1'b0};
			end
		end
		if (cmd.score)
			score_q <= wsum[32:16];
		if (cmd.update && take) begin
			b_pos_q   <= pos_q;
			b_frame_q <= kf_q;
			b_stamp_q <= ks_q;
			b_dist_q  <= sq_root_q;
			b_yaw_q   <= ayaw_q;
			b_score_q <= score_q;
			b_gap_q   <= sep_q;
		end
		if (cmd.emit) begin
			if (qvalid_q && have_best_q) begin
				out_q.found         <= 1'b1;
				out_q.best_position <= b_pos_q;
				out_q.best_frame_id <= b_frame_q;
				out_q.best_stamp    <= b_stamp_q;
				out_q.best_distance <= b_dist_q;
				out_q.best_yaw_gap  <= b_yaw_q;
				out_q.match_score   <= b_score_q[16] ? 16'hFFFF : b_score_q[15:0];
				out_q.best_time_gap <= b_gap_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/loop_candidate_best_match.sv =====
// A query word without the last flag is taken while the sequencer stays idle; a
// keyframe word that passes every gate stalls the input through gate, two squares,
// a 32-step square root, three 16-step divisions and score. A closing word leads to
// the emit state. Words are taken singly; no new keyframe is taken before the shared
// root and divider units finish the last. A stalled result word holds the sequencer.
// Reset clears the query and best-match flags and restores the register defaults.
//------------------------------------------------------------------------------
// loop_candidate_best_match
// Picks the best loop-closure keyframe for a query pose.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module loop_candidate_best_match
	import lcbm_pkg::*;
#(
	parameter int MAX_KEYFRAMES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire item_t       in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output result_t          out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [39:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lcbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_action (in_data.action),
		.in_last   (in_data.last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcbm_dp #(
		.MAX_KEYFRAMES (MAX_KEYFRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
